>>> hw/rtl/lobm_pkg.sv
// Shared types and constants of the limit order book matcher.
package lobm_pkg;

   localparam int BOOK_DEPTH = 32;
   localparam int SLOT_W     = $clog2(BOOK_DEPTH);

   localparam logic [1:0] OP_NEW     = 2'd0;
   localparam logic [1:0] OP_CANCEL  = 2'd1;
   localparam logic [1:0] OP_REPLACE = 2'd2;

   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   localparam logic KIND_FILL = 1'b0;
   localparam logic KIND_DROP = 1'b1;

   // Entry update broadcast to every cell of both books.
   typedef enum logic [2:0] {
      WR_NONE,
      WR_INSERT,
      WR_CLEAR,
      WR_QTY,
      WR_PRICE_QTY
   } wr_kind_type;

   typedef struct packed {
      wr_kind_type       kind;
      logic              side;
      logic [SLOT_W-1:0] idx;
      logic [31:0]       id;
      logic [31:0]       price;
      logic [31:0]       qty;
      logic [31:0]       time_stamp;
   } wr_type;

   // Search token that walks the chain, one cell per cycle.
   typedef struct packed {
      logic              run;
      logic              best_ok;
      logic [SLOT_W-1:0] best_idx;
      logic [31:0]       best_id;
      logic [31:0]       best_price;
      logic [31:0]       best_qty;
      logic [31:0]       best_time;
      logic              free_ok;
      logic [SLOT_W-1:0] free_idx;
      logic              hit_ok;
      logic [SLOT_W-1:0] hit_idx;
   } tok_type;

endpackage

>>> hw/rtl/lobm_cell.sv
// One book slot: holds an entry and folds it into the passing search token.
module lobm_cell import lobm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              my_side,
   input  logic [SLOT_W-1:0] my_idx,
   input  logic [31:0]       key_id,
   input  wr_type            wr,
   input  tok_type           tok_i,
   output tok_type           tok_o
);

   logic        valid_ff;
   logic [31:0] id_ff, price_ff, qty_ff, time_ff;
   tok_type     tok_ff, tok_in;
   logic        mine, better, price_better;

   assign mine = (wr.side == my_side) && (wr.idx == my_idx);

   always_comb begin
      price_better = (my_side == SIDE_SELL) ? (price_ff < tok_i.best_price)
                                            : (price_ff > tok_i.best_price);
      // strict compare keeps the lower slot on a full tie
      better = valid_ff && (!tok_i.best_ok ||
               ((price_ff == tok_i.best_price) ? (time_ff < tok_i.best_time) : price_better));
      tok_in = tok_i;
      if (better) begin
         tok_in.best_ok    = 1'b1;
         tok_in.best_idx   = my_idx;
         tok_in.best_id    = id_ff;
         tok_in.best_price = price_ff;
         tok_in.best_qty   = qty_ff;
         tok_in.best_time  = time_ff;
      end
      if (!valid_ff && !tok_i.free_ok) begin
         tok_in.free_ok  = 1'b1;
         tok_in.free_idx = my_idx;
      end
      if (valid_ff && (id_ff == key_id) && !tok_i.hit_ok) begin
         tok_in.hit_ok  = 1'b1;
         tok_in.hit_idx = my_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         tok_ff <= tok_in;
         if (mine) begin
            unique case (wr.kind)
               WR_INSERT: begin
                  valid_ff <= 1'b1;
                  id_ff    <= wr.id;
                  price_ff <= wr.price;
                  qty_ff   <= wr.qty;
                  time_ff  <= wr.time_stamp;
               end
               WR_CLEAR: valid_ff <= 1'b0;
               WR_QTY: qty_ff <= wr.qty;
               WR_PRICE_QTY: begin
                  price_ff <= wr.price;
                  qty_ff   <= wr.qty;
               end
               default: ;
            endcase
         end
      end
   end

   assign tok_o = tok_ff;

endmodule

>>> hw/rtl/lobm_chain.sv
// One book side: a row of slot cells that the search token walks through.
module lobm_chain import lobm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        my_side,
   input  logic        launch,
   input  logic [31:0] key_id,
   input  wr_type      wr,
   output tok_type     result
);

   tok_type tok [BOOK_DEPTH];
   tok_type seed;

   always_comb begin
      seed     = '0;
      seed.run = launch;
   end

   for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
      lobm_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .my_side(my_side),
         .my_idx (SLOT_W'(i)),
         .key_id (key_id),
         .wr     (wr),
         .tok_i  ((i == 0) ? seed : tok[(i == 0) ? 0 : i - 1]),
         .tok_o  (tok[i])
      );
   end

   assign result = tok[BOOK_DEPTH-1];

endmodule

>>> hw/rtl/limit_order_book_matcher_core.sv
// Top level of the price-time priority limit order book matcher.
// A transaction is taken when start is high and busy is low. Each book side is a row
// of BOOK_DEPTH slot cells. Every decision needs one search token to walk the whole row.
// The decisions are the best opposite order, the own free slot and the id lookup.
// A cancel or in-place replace needs one search; a new order needs one per fill and, if
// quantity remains, one more to rest or drop it, and none at zero quantity.
// A replace that re-enters adds its lookup search.
// At most one result comes out per search, each on rsp_strobe for a single cycle, and
// results cannot be held off; the last one of a transaction carries rsp_last.
// No clearing pass is needed after reset.
module limit_order_book_matcher_core import lobm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic        req_side,
   input  logic [31:0] req_order_id,
   input  logic [31:0] req_price,
   input  logic [31:0] req_quantity,
   input  logic [31:0] req_repl_price,
   input  logic [31:0] req_repl_quantity,
   input  logic [31:0] req_arrival_time,
   output logic        rsp_strobe,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_buyer_id,
   output logic [31:0] rsp_seller_id,
   output logic [31:0] rsp_fill_quantity,
   output logic [31:0] rsp_fill_price,
   output logic [31:0] rsp_later_time,
   output logic [31:0] rsp_fill_sequence,
   output logic        rsp_last
);

   typedef enum logic [2:0] {S_IDLE, S_ENTER, S_WAIT, S_FLUSH} state_type;
   typedef enum logic [1:0] {M_ENTER, M_CANCEL, M_REPLACE} mode_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] buyer;
      logic [31:0] seller;
      logic [31:0] qty;
      logic [31:0] price;
      logic [31:0] later;
      logic [31:0] seq;
   } res_type;

   state_type   state_ff;
   mode_type    mode_ff;
   logic        side_ff, launch_ff;
   logic [31:0] id_ff, price_ff, qty_ff, nprice_ff, nqty_ff, time_ff, counter_ff;
   wr_type      wr_ff;
   logic        pend_ok_ff;
   res_type     pend_ff;
   logic        rsp_strobe_ff, rsp_last_ff;
   res_type     rsp_ff;

   tok_type     buy_res, sell_res, own, opp;
   logic        crosses;
   logic [31:0] fq, fp, lt;
   res_type     fill_res, drop_res;

   lobm_chain u_buy (
      .clock(clock), .reset(reset), .my_side(SIDE_BUY), .launch(launch_ff),
      .key_id(id_ff), .wr(wr_ff), .result(buy_res)
   );
   lobm_chain u_sell (
      .clock(clock), .reset(reset), .my_side(SIDE_SELL), .launch(launch_ff),
      .key_id(id_ff), .wr(wr_ff), .result(sell_res)
   );

   // Decision data for the order being worked.
   always_comb begin
      own   = (side_ff == SIDE_SELL) ? sell_res : buy_res;
      opp   = (side_ff == SIDE_SELL) ? buy_res : sell_res;
      crosses = opp.best_ok && ((side_ff == SIDE_BUY) ? (price_ff >= opp.best_price)
                                                       : (price_ff <= opp.best_price));
      fq = (qty_ff < opp.best_qty) ? qty_ff : opp.best_qty;
      // earlier timestamp sets the price; on a tie the resting order's
      fp = (time_ff < opp.best_time) ? price_ff : opp.best_price;
      lt = (time_ff > opp.best_time) ? time_ff : opp.best_time;
      fill_res.kind   = KIND_FILL;
      fill_res.buyer  = (side_ff == SIDE_BUY) ? id_ff : opp.best_id;
      fill_res.seller = (side_ff == SIDE_BUY) ? opp.best_id : id_ff;
      fill_res.qty    = fq;
      fill_res.price  = fp;
      fill_res.later  = lt;
      fill_res.seq    = counter_ff;
      drop_res.kind   = KIND_DROP;
      drop_res.buyer  = (side_ff == SIDE_BUY) ? id_ff : 32'd0;
      drop_res.seller = (side_ff == SIDE_BUY) ? 32'd0 : id_ff;
      drop_res.qty    = qty_ff;
      drop_res.price  = price_ff;
      drop_res.later  = time_ff;
      drop_res.seq    = 32'd0;
   end

   // Results are held back one step so the last one can be flagged.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= M_ENTER;
         launch_ff     <= 1'b0;
         wr_ff         <= '0;
         pend_ok_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
         counter_ff    <= 32'd0;
      end else begin
         launch_ff     <= 1'b0;
         wr_ff.kind    <= WR_NONE;
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  side_ff   <= req_side;
                  id_ff     <= req_order_id;
                  price_ff  <= req_price;
                  qty_ff    <= req_quantity;
                  nprice_ff <= req_repl_price;
                  nqty_ff   <= req_repl_quantity;
                  time_ff   <= req_arrival_time;
                  unique case (req_operation)
                     OP_NEW: begin
                        mode_ff  <= M_ENTER;
                        state_ff <= S_ENTER;
                     end
                     OP_CANCEL: begin
                        mode_ff   <= M_CANCEL;
                        launch_ff <= 1'b1;
                        state_ff  <= S_WAIT;
                     end
                     OP_REPLACE: begin
                        mode_ff   <= M_REPLACE;
                        launch_ff <= 1'b1;
                        state_ff  <= S_WAIT;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_ENTER: begin
               // pending book write lands this cycle, before the token starts
               if (qty_ff == 32'd0) begin
                  state_ff <= S_FLUSH;
               end else begin
                  launch_ff <= 1'b1;
                  state_ff  <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (buy_res.run) begin
                  wr_ff.side       <= side_ff;
                  wr_ff.id         <= id_ff;
                  wr_ff.price      <= price_ff;
                  wr_ff.qty        <= qty_ff;
                  wr_ff.time_stamp <= time_ff;
                  unique case (mode_ff)
                     M_CANCEL: begin
                        if (own.hit_ok) begin
                           wr_ff.kind <= WR_CLEAR;
                           wr_ff.idx  <= own.hit_idx;
                        end
                        state_ff <= S_FLUSH;
                     end
                     M_REPLACE: begin
                        wr_ff.idx <= own.hit_idx;
                        if (!own.hit_ok) begin
                           state_ff <= S_FLUSH;
                        end else if ((qty_ff < nqty_ff) || (price_ff != nprice_ff)) begin
                           wr_ff.kind <= WR_CLEAR;
                           price_ff   <= nprice_ff;
                           qty_ff     <= nqty_ff;
                           mode_ff    <= M_ENTER;
                           state_ff   <= S_ENTER;
                        end else begin
                           wr_ff.kind  <= WR_PRICE_QTY;
                           wr_ff.price <= nprice_ff;
                           wr_ff.qty   <= nqty_ff;
                           state_ff    <= S_FLUSH;
                        end
                     end
                     default: begin
                        if (crosses) begin
                           wr_ff.side <= ~side_ff;
                           wr_ff.idx  <= opp.best_idx;
                           wr_ff.qty  <= opp.best_qty - fq;
                           wr_ff.kind <= (opp.best_qty == fq) ? WR_CLEAR : WR_QTY;
                           qty_ff     <= qty_ff - fq;
                           counter_ff <= counter_ff + 32'd1;
                           if (pend_ok_ff) begin
                              rsp_strobe_ff <= 1'b1;
                              rsp_last_ff   <= 1'b0;
                              rsp_ff        <= pend_ff;
                           end
                           pend_ok_ff <= 1'b1;
                           pend_ff    <= fill_res;
                           state_ff   <= S_ENTER;
                        end else begin
                           if (own.free_ok) begin
                              wr_ff.kind <= WR_INSERT;
                              wr_ff.idx  <= own.free_idx;
                           end else begin
                              if (pend_ok_ff) begin
                                 rsp_strobe_ff <= 1'b1;
                                 rsp_last_ff   <= 1'b0;
                                 rsp_ff        <= pend_ff;
                              end
                              pend_ok_ff <= 1'b1;
                              pend_ff    <= drop_res;
                           end
                           state_ff <= S_FLUSH;
                        end
                     end
                  endcase
               end
            end
            S_FLUSH: begin
               if (pend_ok_ff) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_last_ff   <= 1'b1;
                  rsp_ff        <= pend_ff;
               end
               pend_ok_ff <= 1'b0;
               state_ff   <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_result_kind   = rsp_ff.kind;
   assign rsp_buyer_id      = rsp_ff.buyer;
   assign rsp_seller_id     = rsp_ff.seller;
   assign rsp_fill_quantity = rsp_ff.qty;
   assign rsp_fill_price    = rsp_ff.price;
   assign rsp_later_time    = rsp_ff.later;
   assign rsp_fill_sequence = rsp_ff.seq;

   // both book rows walk their tokens in lockstep
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      buy_res.run == sell_res.run)
      else $error("book chains out of step");

   // no book update may still be in flight once the block reports idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> wr_ff.kind == WR_NONE)
      else $error("book write while idle");

   // the final result of a transaction is never followed at once by another
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_last_ff |=> !rsp_strobe_ff)
      else $error("result right after last");

   // a dropped remainder does not consume a fill number
   a_drop_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && (rsp_ff.kind == KIND_DROP) |-> rsp_ff.seq == 32'd0)
      else $error("drop carries a fill sequence");

endmodule

>>> bench/tb_limit_order_book_matcher_core.sv
// Self-checking testbench for the limit order book matcher core.
`timescale 1ns / 100ps

module tb_limit_order_book_matcher_core;
   import lobm_pkg::*;

   localparam int NSLOT      = 2 * BOOK_DEPTH;
   localparam int IDLE_LIMIT = 20000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  operation;
      logic        side;
      logic [31:0] order_id;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [31:0] repl_price;
      logic [31:0] repl_quantity;
      logic [31:0] arrival_time;
      int          send_gap;   // idle cycles before this transaction is offered
   } order_cmd_type;

   typedef struct {
      logic        kind;
      logic [31:0] buyer;
      logic [31:0] seller;
      logic [31:0] qty;
      logic [31:0] price;
      logic [31:0] later;
      logic [31:0] seq;
      logic        last;
   } trade_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_operation     = OP_NEW;
   logic        req_side          = SIDE_BUY;
   logic [31:0] req_order_id      = '0;
   logic [31:0] req_price         = '0;
   logic [31:0] req_quantity      = '0;
   logic [31:0] req_repl_price    = '0;
   logic [31:0] req_repl_quantity = '0;
   logic [31:0] req_arrival_time  = '0;
   logic        rsp_strobe;
   logic        rsp_result_kind;
   logic [31:0] rsp_buyer_id;
   logic [31:0] rsp_seller_id;
   logic [31:0] rsp_fill_quantity;
   logic [31:0] rsp_fill_price;
   logic [31:0] rsp_later_time;
   logic [31:0] rsp_fill_sequence;
   logic        rsp_last;

   limit_order_book_matcher_core i_dut (.*);

   always #10 clock = ~clock;

   // Shadow book: slots 0..BOOK_DEPTH-1 buy, the rest sell.
   logic        bk_valid [NSLOT];
   logic [31:0] bk_id    [NSLOT];
   logic [31:0] bk_price [NSLOT];
   logic [31:0] bk_qty   [NSLOT];
   logic [31:0] bk_time  [NSLOT];
   logic [31:0] fill_count;

   order_cmd_type    pending_cmds [$];
   trade_report_type expected_trades [$];
   int  error_count = 0;
   int  idle_cycles = 0;
   int  gap_left = 0;
   int  idle_pct = 0;
   // ids recently entered, per side, so cancels and replaces mostly hit
   logic [31:0] live_ids [2][$];

   function automatic int best_opposite(input logic s);
      int b;
      int base;
      logic better;
      b = -1;
      base = s ? BOOK_DEPTH : 0;
      for (int i = base; i < base + BOOK_DEPTH; i++) begin
         if (!bk_valid[i]) continue;
         if (b < 0) begin
            b = i;
            continue;
         end
         if (bk_price[i] == bk_price[b]) better = bk_time[i] < bk_time[b];
         else better = s ? (bk_price[i] < bk_price[b]) : (bk_price[i] > bk_price[b]);
         if (better) b = i;
      end
      return b;
   endfunction

   function automatic int lookup_id(input logic s, input logic [31:0] id);
      int base;
      base = s ? BOOK_DEPTH : 0;
      for (int i = base; i < base + BOOK_DEPTH; i++)
         if (bk_valid[i] && bk_id[i] == id) return i;
      return -1;
   endfunction

   // Match an incoming order against the opposite book, then rest or drop it.
   task automatic match_and_rest(input logic s, input logic [31:0] id, input logic [31:0] px,
                                 input logic [31:0] q_in, input logic [31:0] t);
      logic [31:0]      q;
      logic [31:0]      tq;
      int               b;
      int               base;
      logic             crossed;
      trade_report_type r;
      q = q_in;
      while (q != 0) begin
         b = best_opposite(~s);
         if (b < 0) break;
         crossed = (s == SIDE_BUY) ? (px >= bk_price[b]) : (px <= bk_price[b]);
         if (!crossed) break;
         tq = (q < bk_qty[b]) ? q : bk_qty[b];
         q -= tq;
         bk_qty[b] -= tq;
         r.kind   = KIND_FILL;
         r.buyer  = (s == SIDE_BUY) ? id : bk_id[b];
         r.seller = (s == SIDE_BUY) ? bk_id[b] : id;
         r.qty    = tq;
         r.price  = (t < bk_time[b]) ? px : bk_price[b];
         r.later  = (t > bk_time[b]) ? t : bk_time[b];
         r.seq    = fill_count;
         r.last   = 1'b0;
         expected_trades.push_back(r);
         fill_count++;
         if (bk_qty[b] == 0) bk_valid[b] = 1'b0;
      end
      if (q == 0) return;
      base = s ? BOOK_DEPTH : 0;
      for (int i = base; i < base + BOOK_DEPTH; i++) begin
         if (!bk_valid[i]) begin
            bk_valid[i] = 1'b1;
            bk_id[i]    = id;
            bk_price[i] = px;
            bk_qty[i]   = q;
            bk_time[i]  = t;
            return;
         end
      end
      r.kind   = KIND_DROP;
      r.buyer  = (s == SIDE_BUY) ? id : 32'd0;
      r.seller = (s == SIDE_BUY) ? 32'd0 : id;
      r.qty    = q;
      r.price  = px;
      r.later  = t;
      r.seq    = '0;
      r.last   = 1'b0;
      expected_trades.push_back(r);
   endtask

   // Apply one accepted transaction to the shadow book.
   task automatic predict_trades(input order_cmd_type c);
      int k;
      int n0;
      n0 = expected_trades.size();
      case (c.operation)
         OP_NEW: begin
            match_and_rest(c.side, c.order_id, c.price, c.quantity, c.arrival_time);
         end
         OP_CANCEL: begin
            k = lookup_id(c.side, c.order_id);
            if (k >= 0) bk_valid[k] = 1'b0;
         end
         OP_REPLACE: begin
            k = lookup_id(c.side, c.order_id);
            if (k >= 0) begin
               if (c.quantity < c.repl_quantity || c.price != c.repl_price) begin
                  bk_valid[k] = 1'b0;
                  match_and_rest(c.side, c.order_id, c.repl_price, c.repl_quantity,
                                 c.arrival_time);
               end else begin
                  bk_price[k] = c.repl_price;
                  bk_qty[k]   = c.repl_quantity;
               end
            end
         end
         default: ;
      endcase
      if (expected_trades.size() > n0) expected_trades[$].last = 1'b1;
   endtask

   // Driver: offers queued transactions, honoring per-item idle gaps.
   always @(posedge clock) begin
      order_cmd_type c;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            c = pending_cmds.pop_front();
            predict_trades(c);
            idle_cycles = 0;
         end
         if ((start && busy) || gap_left > 0) begin
            if (!start) gap_left = gap_left - 1;
         end else if (pending_cmds.size() > 0 && pending_cmds[0].send_gap > 0
                      && gap_left == 0 && !pending_cmds[0].send_gap[31]) begin
            gap_left = pending_cmds[0].send_gap - 1;
            pending_cmds[0].send_gap = -1;
            start <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            c = pending_cmds[0];
            start             <= 1'b1;
            req_operation     <= c.operation;
            req_side          <= c.side;
            req_order_id      <= c.order_id;
            req_price         <= c.price;
            req_quantity      <= c.quantity;
            req_repl_price    <= c.repl_price;
            req_repl_quantity <= c.repl_quantity;
            req_arrival_time  <= c.arrival_time;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobed result must match the oldest expectation.
   always @(posedge clock) begin
      trade_report_type e;
      if (!reset) begin
         if (rsp_strobe) begin
            idle_cycles = 0;
            if (expected_trades.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual kind=%0d buyer=%0d",
                        $time, rsp_result_kind, rsp_buyer_id);
               error_count++;
            end else begin
               e = expected_trades.pop_front();
               if (rsp_result_kind !== e.kind || rsp_buyer_id !== e.buyer ||
                   rsp_seller_id !== e.seller || rsp_fill_quantity !== e.qty ||
                   rsp_fill_price !== e.price || rsp_later_time !== e.later ||
                   rsp_fill_sequence !== e.seq || rsp_last !== e.last) begin
                  $display("%0t: expected kind=%0d buyer=%0d seller=%0d qty=%0d price=%0d",
                           $time, e.kind, e.buyer, e.seller, e.qty, e.price,
                           " time=%0d seq=%0d last=%0d", e.later, e.seq, e.last);
                  $display("%0t: actual   kind=%0d buyer=%0d seller=%0d qty=%0d price=%0d",
                           $time, rsp_result_kind, rsp_buyer_id, rsp_seller_id,
                           rsp_fill_quantity, rsp_fill_price,
                           " time=%0d seq=%0d last=%0d", rsp_later_time,
                           rsp_fill_sequence, rsp_last);
                  error_count++;
               end
            end
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("limit_order_book_matcher_core: mismatch");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(99) < idle_pct) return $urandom_range(1, 12);
      return 0;
   endfunction

   task automatic queue_cmd(input logic [1:0] op, input logic s, input logic [31:0] id,
                            input logic [31:0] px, input logic [31:0] q,
                            input logic [31:0] npx, input logic [31:0] nq,
                            input logic [31:0] t);
      order_cmd_type c;
      c.operation = op; c.side = s; c.order_id = id; c.price = px; c.quantity = q;
      c.repl_price = npx; c.repl_quantity = nq; c.arrival_time = t;
      c.send_gap = pick_gap();
      pending_cmds.push_back(c);
   endtask

   // Random order flow around a moving mid price so books cross often.
   task automatic queue_random(input int count, input logic [31:0] mid);
      logic        s;
      logic [31:0] id;
      logic [31:0] px;
      int          r;
      int          j;
      for (int n = 0; n < count; n++) begin
         s  = 1'($urandom_range(1));
         px = mid + $urandom_range(20) - 10;
         r  = $urandom_range(99);
         if (r < 8) px = $urandom;
         if (r < 55 || live_ids[s].size() == 0) begin
            id = $urandom;
            if (r >= 52) id = $urandom_range(3);   // duplicate ids
            live_ids[s].push_back(id);
            if (live_ids[s].size() > 40) void'(live_ids[s].pop_front());
            queue_cmd(OP_NEW, s, id, px, (r % 9 == 0) ? $urandom : $urandom_range(0, 60),
                      $urandom, $urandom, $urandom_range(500));
         end else begin
            j  = $urandom_range(live_ids[s].size() - 1);
            id = (r % 10 == 0) ? $urandom : live_ids[s][j];
            if (r < 72)
               queue_cmd(OP_CANCEL, s, id, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
            else if (r < 97)
               queue_cmd(OP_REPLACE, s, id, px, $urandom_range(0, 60),
                         (r % 2) ? px : px + $urandom_range(8) - 4,
                         $urandom_range(0, 70), $urandom_range(500));
            else
               queue_cmd(OP_UNUSED, s, id, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < NSLOT; i++) begin
         bk_valid[i] = 1'b0;
         bk_id[i] = '0; bk_price[i] = '0; bk_qty[i] = '0; bk_time[i] = '0;
      end
      fill_count = '0;

      // Directed: extremes, every operation, zero quantity, dup ids, ties.
      queue_cmd(OP_NEW, SIDE_SELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0,
                32'hFFFF_FFFF);
      queue_cmd(OP_NEW, SIDE_BUY, 32'h0, 32'h0, 32'd0, 0, 0, 0);       // zero qty
      queue_cmd(OP_NEW, SIDE_BUY, 32'h0, 32'hFFFF_FFFF, 32'd5, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'h0);                                 // crosses
      queue_cmd(OP_NEW, SIDE_SELL, 10, 100, 7, 0, 0, 5);
      queue_cmd(OP_NEW, SIDE_SELL, 11, 100, 7, 0, 0, 5);               // tie: lower slot
      queue_cmd(OP_NEW, SIDE_SELL, 11, 99, 3, 0, 0, 9);                // duplicate id
      queue_cmd(OP_REPLACE, SIDE_SELL, 11, 100, 7, 100, 0, 3);         // in place to zero
      queue_cmd(OP_REPLACE, SIDE_SELL, 10, 100, 7, 100, 4, 3);         // in place, smaller
      queue_cmd(OP_REPLACE, SIDE_SELL, 10, 100, 4, 101, 4, 7);         // price change
      queue_cmd(OP_REPLACE, SIDE_SELL, 77, 1, 1, 1, 1, 1);             // unknown id
      queue_cmd(OP_CANCEL, SIDE_SELL, 77, 0, 0, 0, 0, 0);              // unknown id
      queue_cmd(OP_UNUSED, SIDE_SELL, 10, 0, 0, 0, 0, 0);              // unused code
      queue_cmd(OP_NEW, SIDE_BUY, 20, 100, 100, 0, 0, 2);              // sweeps, rests
      queue_cmd(OP_CANCEL, SIDE_BUY, 20, 0, 0, 0, 0, 0);
      queue_cmd(OP_CANCEL, SIDE_SELL, 10, 0, 0, 0, 0, 0);
      // Fill the buy side to its depth, then overflow it.
      for (int i = 0; i < BOOK_DEPTH + 1; i++)
         queue_cmd(OP_NEW, SIDE_BUY, 1000 + i, 50, 2, 0, 0, 100 + i);
      // One sell that trades against every resting buy: maximum results.
      queue_cmd(OP_NEW, SIDE_SELL, 2000, 0, 32'hFFFF_FFFF, 0, 0, 0);
      queue_cmd(OP_CANCEL, SIDE_SELL, 2000, 0, 0, 0, 0, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Random phases with varying sender idling.
      idle_pct = 0;  queue_random(80, 1000);
      idle_pct = 56; queue_random(80, 5000);
      idle_pct = 0;  queue_random(70, 32'hFFFF_FFF0);
      idle_pct = 24; queue_random(70, 20);

      wait (pending_cmds.size() == 0 && !start);
      wait (expected_trades.size() == 0);
      repeat (4 * BOOK_DEPTH + 20) @(posedge clock);
      if (error_count == 0 && expected_trades.size() == 0)
         $display("limit_order_book_matcher_core: match");
      else
         $display("limit_order_book_matcher_core: mismatch");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_cell.sv
hw/rtl/lobm_chain.sv
hw/rtl/limit_order_book_matcher_core.sv
bench/tb_limit_order_book_matcher_core.sv
